// ----- rtl/pir_pkg.sv -----
// Shared types, widths and helpers for the pair impulse resolver.
// Used by every module of the block; no dependencies.
package pir_pkg;

  localparam int VW       = 32;
  localparam int NW       = 16;
  localparam int MW       = 32;
  localparam int EW       = 17;
  localparam int SUMW     = MW + 1;
  localparam int QW       = 16;
  localparam int KW       = 37;
  localparam int GW       = 37;
  localparam int PW       = 39;
  localparam int DIV_STEP = 2;
  localparam int DIV_STG  = QW / DIV_STEP;

  localparam logic [EW-1:0] E_ONE = 17'd65536;

  typedef struct packed {
    logic signed [VW-1:0] vax;
    logic signed [VW-1:0] vay;
    logic signed [VW-1:0] vbx;
    logic signed [VW-1:0] vby;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic                 pin_a;
    logic                 pin_b;
    logic                 applied;
    logic [KW-1:0]        k;
  } carry_t;

  function automatic logic [VW-1:0] sat32(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] hi;
    logic signed [PW+1:0] lo;
    hi = (PW+2)'(33'sh0_7fff_ffff);
    lo = -hi - (PW+2)'(1);
    if (v > hi) begin
      return 32'h7fff_ffff;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end else begin
      return v[VW-1:0];
    end
  endfunction

endpackage

// ----- rtl/pir_front.sv -----
// Front end: normal relative velocity, restitution and mass prep, (1+e)*vn.
// Three register stages; depends on pir_pkg.
module pir_front import pir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 i_valid,
  input  logic signed [VW-1:0] i_vax,
  input  logic signed [VW-1:0] i_vay,
  input  logic signed [VW-1:0] i_vbx,
  input  logic signed [VW-1:0] i_vby,
  input  logic signed [NW-1:0] i_nx,
  input  logic signed [NW-1:0] i_ny,
  input  logic [MW-1:0]        i_ma,
  input  logic [MW-1:0]        i_mb,
  input  logic [EW-1:0]        i_ea,
  input  logic [EW-1:0]        i_eb,
  input  logic                 i_pin_a,
  input  logic                 i_pin_b,
  output logic                 o_valid,
  output carry_t               o_carry,
  output logic [MW-1:0]        o_ma,
  output logic [SUMW-1:0]      o_sum
);

  logic                 v1_r, v2_r, v3_r;
  carry_t               c1_r, c2_r, c3_r;
  logic signed [48:0]   px_r, py_r;
  logic [EW-1:0]        e_r;
  logic [MW-1:0]        ma1_r, mb1_r, ma2_r, ma3_r;
  logic [SUMW-1:0]      sum2_r, sum3_r;
  logic [34:0]          v16_r;
  logic [17:0]          f_r;

  logic signed [32:0]   dx_nxt, dy_nxt;
  logic [EW-1:0]        emax_nxt, e_nxt;
  logic signed [48:0]   vn_nxt, vnr_nxt;
  logic [52:0]          kp_nxt;
  carry_t               c1_nxt, c2_nxt, c3_nxt;

  always_comb begin
    dx_nxt   = 33'(i_vbx) - 33'(i_vax);
    dy_nxt   = 33'(i_vby) - 33'(i_vay);
    emax_nxt = (i_ea > i_eb) ? i_ea : i_eb;
    e_nxt    = (emax_nxt > E_ONE) ? E_ONE : emax_nxt;
    c1_nxt         = '0;
    c1_nxt.vax     = i_vax;
    c1_nxt.vay     = i_vay;
    c1_nxt.vbx     = i_vbx;
    c1_nxt.vby     = i_vby;
    c1_nxt.nx      = i_nx;
    c1_nxt.ny      = i_ny;
    c1_nxt.pin_a   = i_pin_a;
    c1_nxt.pin_b   = i_pin_b;
    vn_nxt   = px_r + py_r;
    vnr_nxt  = vn_nxt + 49'sd8192;
    kp_nxt   = 53'(v16_r) * 53'(f_r) + 53'd32768;
    c2_nxt         = c1_r;
    c2_nxt.applied = (vn_nxt > 49'sd0);
    c3_nxt         = c2_r;
    c3_nxt.k       = kp_nxt[52:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= i_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= c1_nxt;
      px_r  <= dx_nxt * 49'(i_nx);
      py_r  <= dy_nxt * 49'(i_ny);
      e_r   <= e_nxt;
      ma1_r <= (i_ma == '0) ? MW'(1) : i_ma;
      mb1_r <= (i_mb == '0) ? MW'(1) : i_mb;

      c2_r         <= c2_nxt;
      v16_r        <= vnr_nxt[48:14];
      f_r          <= 18'(E_ONE) + 18'(e_r);
      ma2_r        <= ma1_r;
      sum2_r       <= SUMW'(ma1_r) + SUMW'(mb1_r);

      c3_r   <= c3_nxt;
      ma3_r  <= ma2_r;
      sum3_r <= sum2_r;
    end
  end

  assign o_valid = v3_r;
  assign o_carry = c3_r;
  assign o_ma    = ma3_r;
  assign o_sum   = sum3_r;

endmodule

// ----- rtl/pir_div.sv -----
// Pipelined restoring divider for the mass share floor(mA*2^16/(mA+mB)).
// Two quotient bits per stage; depends on pir_pkg.
module pir_div import pir_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_valid,
  input  carry_t          i_carry,
  input  logic [MW-1:0]   i_ma,
  input  logic [SUMW-1:0] i_sum,
  output logic            o_valid,
  output carry_t          o_carry,
  output logic [QW-1:0]   o_q,
  output logic            o_rem_nz
);

  logic            v_r [DIV_STG];
  carry_t          c_r [DIV_STG];
  logic [SUMW-1:0] r_r [DIV_STG];
  logic [SUMW-1:0] d_r [DIV_STG];
  logic [QW-1:0]   q_r [DIV_STG];

  for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
    logic            v_in;
    carry_t          c_in;
    logic [SUMW-1:0] r_in, d_in, r_nxt;
    logic [QW-1:0]   q_in, q_nxt;
    logic [SUMW:0]   sh;

    if (g == 0) begin : g_head
      assign v_in = i_valid;
      assign c_in = i_carry;
      assign r_in = SUMW'(i_ma);
      assign d_in = i_sum;
      assign q_in = '0;
    end else begin : g_body
      assign v_in = v_r[g-1];
      assign c_in = c_r[g-1];
      assign r_in = r_r[g-1];
      assign d_in = d_r[g-1];
      assign q_in = q_r[g-1];
    end

    always_comb begin
      r_nxt = r_in;
      q_nxt = q_in;
      sh    = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
        sh = {r_nxt, 1'b0};
        if (sh >= {1'b0, d_in}) begin
          sh    = sh - {1'b0, d_in};
          q_nxt = {q_nxt[QW-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[QW-2:0], 1'b0};
        end
        r_nxt = sh[SUMW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[g] <= c_in;
        r_r[g] <= r_nxt;
        d_r[g] <= d_in;
        q_r[g] <= q_nxt;
      end
    end
  end

  assign o_valid  = v_r[DIV_STG-1];
  assign o_carry  = c_r[DIV_STG-1];
  assign o_q      = q_r[DIV_STG-1];
  assign o_rem_nz = (r_r[DIV_STG-1] != '0);

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STG-1] |-> (r_r[DIV_STG-1] < d_r[DIV_STG-1]))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (d_r[0] > r_r[0]) && (d_r[0] >= SUMW'(2)))
    else $error("divisor too small at first stage");

endmodule

// ----- rtl/pir_apply.sv -----
// Back end: mass shares, per-body impulse, scale by normal, saturating update.
// Three register stages, the last is the output register; depends on pir_pkg.
module pir_apply import pir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 i_valid,
  input  carry_t               i_carry,
  input  logic [QW-1:0]        i_q,
  input  logic                 i_rem_nz,
  output logic                 o_valid,
  output logic signed [VW-1:0] o_vax,
  output logic signed [VW-1:0] o_vay,
  output logic signed [VW-1:0] o_vbx,
  output logic signed [VW-1:0] o_vby,
  output logic                 o_applied
);

  logic                 v1_r, v2_r, v3_r;
  carry_t               c1_r, c2_r;
  logic [GW-1:0]        ga_r, gb_r;
  logic [PW-1:0]        pax_r, pay_r, pbx_r, pby_r;
  logic signed [VW-1:0] vax_r, vay_r, vbx_r, vby_r;
  logic                 app_r;

  logic [QW:0]          wa17_nxt;
  logic [52:0]          gap_nxt, gbp_nxt;
  logic [NW-1:0]        mx_nxt, my_nxt;
  logic [52:0]          pax_nxt, pay_nxt, pbx_nxt, pby_nxt;
  logic signed [PW:0]   cax_nxt, cay_nxt, cbx_nxt, cby_nxt;
  logic signed [PW+1:0] sax_nxt, say_nxt, sbx_nxt, sby_nxt;
  logic                 upd_a, upd_b;

  always_comb begin
    wa17_nxt = (QW+1)'(E_ONE) - (QW+1)'(i_q) - (QW+1)'(i_rem_nz);
    gap_nxt  = 53'(i_carry.k) * 53'(wa17_nxt[QW-1:0]) + 53'd32768;
    gbp_nxt  = 53'(i_carry.k) * 53'(i_q) + 53'd32768;

    mx_nxt   = c1_r.nx[NW-1] ? NW'(-c1_r.nx) : NW'(c1_r.nx);
    my_nxt   = c1_r.ny[NW-1] ? NW'(-c1_r.ny) : NW'(c1_r.ny);
    pax_nxt  = 53'(ga_r) * 53'(mx_nxt) + 53'd8192;
    pay_nxt  = 53'(ga_r) * 53'(my_nxt) + 53'd8192;
    pbx_nxt  = 53'(gb_r) * 53'(mx_nxt) + 53'd8192;
    pby_nxt  = 53'(gb_r) * 53'(my_nxt) + 53'd8192;

    cax_nxt  = c2_r.nx[NW-1] ? -$signed({1'b0, pax_r}) : $signed({1'b0, pax_r});
    cay_nxt  = c2_r.ny[NW-1] ? -$signed({1'b0, pay_r}) : $signed({1'b0, pay_r});
    cbx_nxt  = c2_r.nx[NW-1] ? -$signed({1'b0, pbx_r}) : $signed({1'b0, pbx_r});
    cby_nxt  = c2_r.ny[NW-1] ? -$signed({1'b0, pby_r}) : $signed({1'b0, pby_r});
    sax_nxt  = (PW+2)'(c2_r.vax) + (PW+2)'(cax_nxt);
    say_nxt  = (PW+2)'(c2_r.vay) + (PW+2)'(cay_nxt);
    sbx_nxt  = (PW+2)'(c2_r.vbx) - (PW+2)'(cbx_nxt);
    sby_nxt  = (PW+2)'(c2_r.vby) - (PW+2)'(cby_nxt);
    upd_a    = c2_r.applied && !c2_r.pin_a;
    upd_b    = c2_r.applied && !c2_r.pin_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= i_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= i_carry;
      ga_r  <= gap_nxt[52:16];
      gb_r  <= gbp_nxt[52:16];

      c2_r  <= c1_r;
      pax_r <= pax_nxt[52:14];
      pay_r <= pay_nxt[52:14];
      pbx_r <= pbx_nxt[52:14];
      pby_r <= pby_nxt[52:14];

      vax_r <= upd_a ? sat32(sax_nxt) : c2_r.vax;
      vay_r <= upd_a ? sat32(say_nxt) : c2_r.vay;
      vbx_r <= upd_b ? sat32(sbx_nxt) : c2_r.vbx;
      vby_r <= upd_b ? sat32(sby_nxt) : c2_r.vby;
      app_r <= c2_r.applied;
    end
  end

  assign o_valid   = v3_r;
  assign o_vax     = vax_r;
  assign o_vay     = vay_r;
  assign o_vbx     = vbx_r;
  assign o_vby     = vby_r;
  assign o_applied = app_r;

  a_no_impulse_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) && v3_r && !app_r |->
      (vax_r == $past(c2_r.vax)) && (vby_r == $past(c2_r.vby)))
    else $error("velocity changed without impulse");

  a_pinned_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) && v3_r && $past(c2_r.pin_b) |->
      (vbx_r == $past(c2_r.vbx)) && (vby_r == $past(c2_r.vby)))
    else $error("pinned body B velocity changed");

endmodule

// ----- rtl/pair_impulse_resolver_2d.sv -----
// Pair impulse resolver, 2D: one contact per beat in, one result beat out.
// Pipeline stages: 3 front, 8 divider, 3 back incl. output register.
// Throughput one contact per cycle; the whole pipe advances together and
// holds while the output register is full and stalled.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on pir_pkg, pir_front, pir_div, pir_apply.
module pair_impulse_resolver_2d import pir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [VW-1:0] in_vel_a_x,
  input  logic signed [VW-1:0] in_vel_a_y,
  input  logic signed [VW-1:0] in_vel_b_x,
  input  logic signed [VW-1:0] in_vel_b_y,
  input  logic signed [NW-1:0] in_normal_x,
  input  logic signed [NW-1:0] in_normal_y,
  input  logic [MW-1:0]        in_mass_a,
  input  logic [MW-1:0]        in_mass_b,
  input  logic [EW-1:0]        in_restitution_a,
  input  logic [EW-1:0]        in_restitution_b,
  input  logic                 in_pinned_a,
  input  logic                 in_pinned_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VW-1:0] out_new_vel_a_x,
  output logic signed [VW-1:0] out_new_vel_a_y,
  output logic signed [VW-1:0] out_new_vel_b_x,
  output logic signed [VW-1:0] out_new_vel_b_y,
  output logic                 out_impulse_applied
);

  logic            en;
  logic            f_valid, d_valid;
  carry_t          f_carry, d_carry;
  logic [MW-1:0]   f_ma;
  logic [SUMW-1:0] f_sum;
  logic [QW-1:0]   d_q;
  logic            d_rem_nz;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  pir_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (in_valid),
    .i_vax   (in_vel_a_x),
    .i_vay   (in_vel_a_y),
    .i_vbx   (in_vel_b_x),
    .i_vby   (in_vel_b_y),
    .i_nx    (in_normal_x),
    .i_ny    (in_normal_y),
    .i_ma    (in_mass_a),
    .i_mb    (in_mass_b),
    .i_ea    (in_restitution_a),
    .i_eb    (in_restitution_b),
    .i_pin_a (in_pinned_a),
    .i_pin_b (in_pinned_b),
    .o_valid (f_valid),
    .o_carry (f_carry),
    .o_ma    (f_ma),
    .o_sum   (f_sum)
  );

  pir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .i_valid  (f_valid),
    .i_carry  (f_carry),
    .i_ma     (f_ma),
    .i_sum    (f_sum),
    .o_valid  (d_valid),
    .o_carry  (d_carry),
    .o_q      (d_q),
    .o_rem_nz (d_rem_nz)
  );

  pir_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .i_valid   (d_valid),
    .i_carry   (d_carry),
    .i_q       (d_q),
    .i_rem_nz  (d_rem_nz),
    .o_valid   (out_valid),
    .o_vax     (out_new_vel_a_x),
    .o_vay     (out_new_vel_a_y),
    .o_vbx     (out_new_vel_b_x),
    .o_vby     (out_new_vel_b_y),
    .o_applied (out_impulse_applied)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> out_valid && $stable(out_impulse_applied))
    else $error("result changed while stalled");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for pair_impulse_resolver_2d: directed and random contacts,
// predicted in-bench and compared beat by beat. Depends on pir_pkg and the RTL.
module tb_top;
  import pir_pkg::*;

  typedef struct {
    logic signed [VW-1:0] vax, vay, vbx, vby;
    logic signed [NW-1:0] nx, ny;
    logic [MW-1:0]        ma, mb;
    logic [EW-1:0]        ea, eb;
    logic                 pa, pb;
  } contact_t;

  typedef struct {
    logic signed [VW-1:0] vax, vay, vbx, vby;
    logic                 applied;
  } vel_result_t;

  localparam int N_RANDOM   = 1000;
  localparam int HOLD_AT    = 600;
  localparam int WD_LIMIT   = 5000;
  localparam int DRAIN_WAIT = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VW-1:0] in_vel_a_x = '0, in_vel_a_y = '0, in_vel_b_x = '0, in_vel_b_y = '0;
  logic signed [NW-1:0] in_normal_x = '0, in_normal_y = '0;
  logic [MW-1:0] in_mass_a = '0, in_mass_b = '0;
  logic [EW-1:0] in_restitution_a = '0, in_restitution_b = '0;
  logic in_pinned_a = 1'b0, in_pinned_b = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] out_new_vel_a_x, out_new_vel_a_y, out_new_vel_b_x, out_new_vel_b_y;
  logic out_impulse_applied;

  contact_t    pending_contacts[$];
  vel_result_t expected_vels[$];
  contact_t    cur_contact;
  int          errors = 0;
  int          sent_cnt = 0;
  int          cyc = 0;
  int          quiet_cycles = 0;

  pair_impulse_resolver_2d u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint scale_normal(logic [63:0] g, logic signed [NW-1:0] n);
    logic [63:0] mag, p;
    mag = (n < 0) ? 64'(-longint'(n)) : 64'(longint'(n));
    p = (g * mag + 64'd8192) >> 14;
    return (n < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [VW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic vel_result_t resolve_contact(contact_t c);
    longint ax, ay, bx, by, vn;
    logic [63:0] e, ma, mb, v16, k, sum, wa, wb, ga, gb;
    vel_result_t r;
    ax = c.vax; ay = c.vay; bx = c.vbx; by = c.vby;
    r.applied = 1'b0;
    vn = (bx - ax) * longint'(c.nx) + (by - ay) * longint'(c.ny);
    if (vn > 0) begin
      e = (c.ea > c.eb) ? 64'(c.ea) : 64'(c.eb);
      if (e > 64'd65536) e = 64'd65536;
      ma = (c.ma == 0) ? 64'd1 : 64'(c.ma);
      mb = (c.mb == 0) ? 64'd1 : 64'(c.mb);
      v16 = (64'(vn) + 64'd8192) >> 14;
      k = (v16 * (64'd65536 + e) + 64'd32768) >> 16;
      sum = ma + mb;
      wa = (mb << 16) / sum;
      wb = (ma << 16) / sum;
      ga = (k * wa + 64'd32768) >> 16;
      gb = (k * wb + 64'd32768) >> 16;
      if (!c.pa) begin
        ax = ax + scale_normal(ga, c.nx);
        ay = ay + scale_normal(ga, c.ny);
      end
      if (!c.pb) begin
        bx = bx - scale_normal(gb, c.nx);
        by = by - scale_normal(gb, c.ny);
      end
      r.applied = 1'b1;
    end
    r.vax = clamp32(ax); r.vay = clamp32(ay);
    r.vbx = clamp32(bx); r.vby = clamp32(by);
    return r;
  endfunction

  function automatic logic signed [VW-1:0] rand_vel();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic signed [NW-1:0] rand_normal();
    if ($urandom_range(0, 9) == 0) return NW'($urandom);
    return 16'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  function automatic logic [MW-1:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      2: return 32'hffff_ffff - $urandom_range(0, 3);
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [EW-1:0] rand_rest();
    if ($urandom_range(0, 9) == 0) return EW'($urandom);
    return EW'($urandom_range(0, 65536));
  endfunction

  function automatic contact_t make_contact(
      logic signed [VW-1:0] vax, vay, vbx, vby, logic signed [NW-1:0] nx, ny,
      logic [MW-1:0] ma, mb, logic [EW-1:0] ea, eb, logic pa, pb);
    contact_t c;
    c.vax = vax; c.vay = vay; c.vbx = vbx; c.vby = vby; c.nx = nx; c.ny = ny;
    c.ma = ma; c.mb = mb; c.ea = ea; c.eb = eb; c.pa = pa; c.pb = pb;
    return c;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit idle_roll();
    return (cyc < 200 || cyc >= 500) && ($urandom_range(0, 99) < 10);
  endfunction

  // driver
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (in_valid && !in_stall) begin
      expected_vels.push_back(resolve_contact(cur_contact));
      sent_cnt <= sent_cnt + 1;
    end
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_contacts.size() != 0 && !idle_roll() &&
          !(sent_cnt + (in_valid ? 1 : 0) == HOLD_AT && expected_vels.size() != 0
            || sent_cnt == HOLD_AT && in_valid)) begin
        cur_contact = pending_contacts.pop_front();
        in_vel_a_x <= cur_contact.vax; in_vel_a_y <= cur_contact.vay;
        in_vel_b_x <= cur_contact.vbx; in_vel_b_y <= cur_contact.vby;
        in_normal_x <= cur_contact.nx; in_normal_y <= cur_contact.ny;
        in_mass_a <= cur_contact.ma; in_mass_b <= cur_contact.mb;
        in_restitution_a <= cur_contact.ea; in_restitution_b <= cur_contact.eb;
        in_pinned_a <= cur_contact.pa; in_pinned_b <= cur_contact.pb;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vel_result_t w;
    out_stall <= idle_roll();
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vels.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        w = expected_vels.pop_front();
        if (out_new_vel_a_x !== w.vax) report("new_vel_a_x", out_new_vel_a_x, w.vax);
        if (out_new_vel_a_y !== w.vay) report("new_vel_a_y", out_new_vel_a_y, w.vay);
        if (out_new_vel_b_x !== w.vbx) report("new_vel_b_x", out_new_vel_b_x, w.vbx);
        if (out_new_vel_b_y !== w.vby) report("new_vel_b_y", out_new_vel_b_y, w.vby);
        if (out_impulse_applied !== w.applied)
          report("impulse_applied", out_impulse_applied, w.applied);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("** pair_impulse_resolver_2d: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    // approaching, symmetric
    pending_contacts.push_back(make_contact(32'sh0001_0000, 0, -32'sh0001_0000, 0,
      -16'sd16384, 0, 32'h0001_0000, 32'h0001_0000, 17'd32768, 17'd0, 0, 0));
    // separating and touching
    pending_contacts.push_back(make_contact(32'sh0001_0000, 0, -32'sh0001_0000, 0,
      16'sd16384, 0, 32'h0001_0000, 32'h0002_0000, 17'd0, 17'd0, 0, 0));
    pending_contacts.push_back(make_contact(5, 7, 5, 7, 16'sd16384, 16'sd16384,
      1, 1, 0, 0, 0, 0));
    // pinned each way and both
    for (int i = 1; i < 4; i++)
      pending_contacts.push_back(make_contact(0, 32'sh0003_0000, 0, -32'sh0002_0000,
        16'sd11585, -16'sd11585, 32'h0004_0000, 32'h0001_0000, 17'd65536, 17'd100,
        i[0], i[1]));
    // zero masses, max masses
    pending_contacts.push_back(make_contact(32'sh0010_0000, 0, 0, 0, -16'sd16384, 0,
      0, 32'h0001_0000, 0, 0, 0, 0));
    pending_contacts.push_back(make_contact(32'sh0010_0000, 0, 0, 0, -16'sd16384, 0,
      0, 0, 17'd1000, 17'd1000, 0, 0));
    pending_contacts.push_back(make_contact(32'sh0010_0000, 32'sh0010_0000, 0, 0,
      -16'sd16384, -16'sd16384, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0));
    pending_contacts.push_back(make_contact(32'sh0010_0000, 0, 0, 0, -16'sd16384, 0,
      32'hffff_ffff, 1, 0, 0, 0, 0));
    // restitution above one
    pending_contacts.push_back(make_contact(32'sh0002_0000, 0, 0, 0, -16'sd16384, 0,
      32'h0001_0000, 32'h0001_0000, 17'h1ffff, 17'h10001, 0, 0));
    // extreme velocities and non-unit normals, saturating
    pending_contacts.push_back(make_contact(32'h7fff_ffff, 32'h7fff_ffff,
      32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 1, 32'hffff_ffff,
      17'h1ffff, 17'h1ffff, 0, 0));
    pending_contacts.push_back(make_contact(32'h8000_0000, 32'h8000_0000,
      32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 32'hffff_ffff, 1,
      17'h1ffff, 0, 0, 0));
    pending_contacts.push_back(make_contact(32'h8000_0000, 0, 32'h7fff_ffff, 0,
      16'h7fff, 16'h8000, 32'h0001_0000, 32'h0001_0000, 17'd65536, 17'd65536, 0, 0));
    pending_contacts.push_back(make_contact(32'hffff_ffff, 32'hffff_ffff,
      32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff,
      32'hffff_ffff, 17'h1ffff, 17'h1ffff, 1, 1));
    for (int i = 0; i < N_RANDOM; i++)
      pending_contacts.push_back(make_contact(rand_vel(), rand_vel(), rand_vel(),
        rand_vel(), rand_normal(), rand_normal(), rand_mass(), rand_mass(),
        rand_rest(), rand_rest(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_contacts.size() != 0 || in_valid || expected_vels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("** pair_impulse_resolver_2d: PASSED **");
    end else begin
      $display("** pair_impulse_resolver_2d: FAILED **");
    end
    $finish;
  end

endmodule
